// ===== rtl/core/ultrasonic_echo_ranger_top_assert.svh =====
// Assertion macros for the ultrasonic echo ranger.
// Used by the top level; relies on the clock and reset named in each use.
`ifndef ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UER_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked out of reset.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies.
package uer_pkg;

  localparam int unsigned CNT_W      = 17;
  localparam int unsigned SPEED_W    = 10;
  localparam int unsigned MAXD_W     = 23;
  localparam int unsigned DIST_W     = 26;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;

  localparam int unsigned TRIG_LOW_TICKS_DEF  = 40;
  localparam int unsigned TRIG_HIGH_TICKS_DEF = 100;

  localparam logic [SPEED_W-1:0] SPEED_RST   = SPEED_W'(343);
  localparam logic [CNT_W-1:0]   TIMEOUT_RST = CNT_W'(11662);
  localparam logic [MAXD_W-1:0]  MAXD_RST    = MAXD_W'(2000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED   = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_MAXDIST = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_MEASURE   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_MEASURED = 2'd0,
    ST_BUSY     = 2'd1,
    ST_NO_ECHO  = 2'd2
  } status_e;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [CNT_W-1:0]   timeout;
    logic [MAXD_W-1:0]  max_dist;
  } cfg_t;

  typedef struct packed {
    logic              trigger;
    logic              done;
    status_e           status;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

// ===== rtl/core/uer_cfg_regs.sv =====
// Configuration registers of the ultrasonic echo ranger.
// Depends on uer_pkg.
module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Write the addressed register; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed    <= SPEED_RST;
      cfg_q.timeout  <= TIMEOUT_RST;
      cfg_q.max_dist <= MAXD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPEED:   cfg_q.speed    <= cfg_data_i[SPEED_W-1:0];
        CFG_TIMEOUT: cfg_q.timeout  <= cfg_data_i[CNT_W-1:0];
        CFG_MAXDIST: cfg_q.max_dist <= cfg_data_i[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/uer_fsm.sv =====
// Measurement sequencer: phase state, tick counters and the result of one tick.
// Depends on uer_pkg.
module uer_fsm
  import uer_pkg::*;
#(
  parameter int unsigned TRIG_LOW_TICKS  = TRIG_LOW_TICKS_DEF,
  parameter int unsigned TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic echo_i,
  input  logic start_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam logic [CNT_W-1:0] LowTicks  = CNT_W'(TRIG_LOW_TICKS);
  localparam logic [CNT_W-1:0] HighTicks = CNT_W'(TRIG_HIGH_TICKS);
  localparam logic [CNT_W-1:0] OneTick   = CNT_W'(1);

  phase_e                     phase_q, phase_d;
  logic   [CNT_W-1:0]         count_q, count_d;
  logic   [CNT_W-1:0]         width_q, width_d;
  logic   [CNT_W-1:0]         count_inc, count_sat, width_sat, rep_width;
  logic                       rise_ok, width_full;
  logic   [CNT_W+SPEED_W-1:0] product;

  // Shared tick arithmetic
  always_comb begin
    count_inc  = count_q + OneTick;
    count_sat  = (count_q == '1) ? count_q : count_inc;
    width_sat  = (width_q == '1) ? width_q : width_q + OneTick;
    rise_ok    = echo_i && (count_q < cfg_i.timeout);
    width_full = width_sat >= cfg_i.timeout;
    if (phase_q == PH_WAIT_RISE) begin
      rep_width = OneTick;
    end else if (echo_i) begin
      rep_width = width_sat;
    end else begin
      rep_width = width_q;
    end
    product = rep_width * cfg_i.speed;
  end

  // Next phase and counters
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    width_d = width_q;
    case (phase_q)
      PH_TRIG_LOW: begin
        count_d = count_inc;
        if (count_inc >= LowTicks) begin
          phase_d = PH_TRIG_HIGH;
          count_d = '0;
        end
      end
      PH_TRIG_HIGH: begin
        count_d = count_inc;
        if (count_inc >= HighTicks) begin
          phase_d = PH_WAIT_RISE;
          count_d = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (rise_ok) begin
          width_d = OneTick;
          count_d = '0;
          phase_d = (OneTick >= cfg_i.timeout) ? PH_IDLE : PH_MEASURE;
        end else if (count_sat >= cfg_i.timeout) begin
          phase_d = PH_IDLE;
          count_d = '0;
        end else begin
          count_d = count_sat;
        end
      end
      PH_MEASURE: begin
        if (!echo_i) begin
          phase_d = PH_IDLE;
          count_d = '0;
        end else begin
          width_d = width_sat;
          if (width_full) begin
            phase_d = PH_IDLE;
            count_d = '0;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (start_i && !echo_i) begin
          phase_d = PH_TRIG_LOW;
          count_d = '0;
          width_d = '0;
        end
      end
    endcase
  end

  // Result of this tick
  always_comb begin
    res_o = '{trigger: 1'b0, done: 1'b0, status: ST_MEASURED, distance: '0};
    case (phase_q)
      PH_TRIG_LOW: ;
      PH_TRIG_HIGH: res_o.trigger = 1'b1;
      PH_WAIT_RISE: begin
        if (rise_ok) begin
          if (OneTick >= cfg_i.timeout) begin
            res_o.done     = 1'b1;
            res_o.distance = product[DIST_W:1];
          end
        end else if (count_sat >= cfg_i.timeout) begin
          res_o.done   = 1'b1;
          res_o.status = ST_NO_ECHO;
        end
      end
      PH_MEASURE: begin
        if (!echo_i || width_full) begin
          res_o.done     = 1'b1;
          res_o.distance = product[DIST_W:1];
        end
      end
      default: begin
        if (start_i && echo_i) begin
          res_o.done     = 1'b1;
          res_o.status   = ST_BUSY;
          res_o.distance = DIST_W'(cfg_i.max_dist);
        end
      end
    endcase
  end

  // Advance state once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      width_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      width_q <= width_d;
    end
  end

endmodule

// ===== rtl/core/ultrasonic_echo_ranger_top.sv =====
// Ultrasonic echo ranger: takes one sampled tick per clock cycle and returns one
// result per tick, which passes through the input register, then the
// sequencer logic and one 17x10 multiply into the result register. A stalled
// result blocks new ticks only once the input register is also full.
// Depends on uer_pkg, uer_cfg_regs, uer_fsm and the assertion macro header.
`include "ultrasonic_echo_ranger_top_assert.svh"

module ultrasonic_echo_ranger_top
  import uer_pkg::*;
#(
  parameter int unsigned TRIG_LOW_TICKS  = TRIG_LOW_TICKS_DEF,
  parameter int unsigned TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  echo_level_i,
  input  logic                  start_request_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  trigger_level_o,
  output logic                  done_res_o,
  output logic [1:0]            status_o,
  output logic [DIST_W-1:0]     distance_um_o
);

  cfg_t cfg;
  res_t res, res_q;
  logic s1_valid_q, echo_q, start_q;
  logic out_free, s1_adv, in_xfer;

  uer_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline control
  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer || s1_adv) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      echo_q  <= echo_level_i;
      start_q <= start_request_i;
    end
  end

  uer_fsm #(
    .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
    .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS)
  ) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .echo_i  (echo_q),
    .start_i (start_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res;
    end
  end

  assign trigger_level_o = res_q.trigger;
  assign done_res_o      = res_q.done;
  assign status_o        = res_q.status;
  assign distance_um_o   = res_q.distance;

  // Checks on the result encoding and the stall path
  `UER_ASSERT_IMPL(a_idle_res_zero, clk_i, rst_ni, out_valid_o && !done_res_o,
                   status_o == ST_MEASURED && distance_um_o == '0)
  `UER_ASSERT_IMPL(a_trig_not_done, clk_i, rst_ni, out_valid_o && trigger_level_o,
                   !done_res_o)
  `UER_ASSERT_IMPL(a_no_echo_zero, clk_i, rst_ni, out_valid_o && status_o == ST_NO_ECHO,
                   distance_um_o == '0)
  `UER_ASSERT_NEXT(a_stall_holds_s1, clk_i, rst_ni, in_stall_o, s1_valid_q)

endmodule

// ===== dv/ultrasonic_echo_ranger_top_tb.sv =====
// Self-checking testbench for ultrasonic_echo_ranger_top: a tick-level predictor
// against the block's result stream, under random valid/stall pressure.
// Depends on uer_pkg and the ranger RTL only.
module ultrasonic_echo_ranger_top_tb;
  import uer_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned TICKS_PER_SETTING = 170;
  localparam int unsigned NUM_SETTINGS = 6;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_SPEED;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  echo_level_i = 1'b0;
  logic                  start_request_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  trigger_level_o;
  logic                  done_res_o;
  logic [1:0]            status_o;
  logic [DIST_W-1:0]     distance_um_o;

  ultrasonic_echo_ranger_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .echo_level_i    (echo_level_i),
    .start_request_i (start_request_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .trigger_level_o (trigger_level_o),
    .done_res_o      (done_res_o),
    .status_o        (status_o),
    .distance_um_o   (distance_um_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of the configuration and sequencer state, reset values
  logic [SPEED_W-1:0] spd = SPEED_RST;
  logic [CNT_W-1:0]   tmo = TIMEOUT_RST;
  logic [MAXD_W-1:0]  maxd = MAXD_RST;
  phase_e             ph = PH_IDLE;
  logic [CNT_W-1:0]   ph_cnt = '0;
  logic [CNT_W-1:0]   echo_width = '0;

  res_t pending_readings[$];
  res_t oldest;
  int   mismatch_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_off_req = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  // Report the counted pulse width as a distance and go back to idle
  function automatic res_t width_report();
    res_t r;
    logic [CNT_W+SPEED_W-1:0] prod;
    prod = echo_width * spd;
    r = '0;
    r.done = 1'b1;
    r.status = ST_MEASURED;
    r.distance = prod[CNT_W+SPEED_W-1:1];
    ph = PH_IDLE;
    ph_cnt = '0;
    return r;
  endfunction

  // Advance the sequencer by one tick and return the reading it presents
  function automatic res_t ranger_tick(input logic echo, input logic start);
    res_t r;
    r = '0;
    case (ph)
      PH_TRIG_LOW: begin
        ph_cnt = ph_cnt + 1'b1;
        if (ph_cnt >= TRIG_LOW_TICKS_DEF) begin
          ph = PH_TRIG_HIGH;
          ph_cnt = '0;
        end
      end
      PH_TRIG_HIGH: begin
        r.trigger = 1'b1;
        ph_cnt = ph_cnt + 1'b1;
        if (ph_cnt >= TRIG_HIGH_TICKS_DEF) begin
          ph = PH_WAIT_RISE;
          ph_cnt = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo && ph_cnt < tmo) begin
          // the rising tick already counts as one tick of width
          echo_width = CNT_W'(1);
          ph = PH_MEASURE;
          ph_cnt = '0;
          if (echo_width >= tmo) r = width_report();
        end else begin
          if (ph_cnt != '1) ph_cnt = ph_cnt + 1'b1;
          if (ph_cnt >= tmo) begin
            r.done = 1'b1;
            r.status = ST_NO_ECHO;
            ph = PH_IDLE;
            ph_cnt = '0;
          end
        end
      end
      PH_MEASURE: begin
        if (!echo) begin
          r = width_report();
        end else begin
          if (echo_width != '1) echo_width = echo_width + 1'b1;
          if (echo_width >= tmo) r = width_report();
        end
      end
      default: begin
        ph = PH_IDLE;
        if (start && echo) begin
          r.done = 1'b1;
          r.status = ST_BUSY;
          r.distance = DIST_W'(maxd);
        end else if (start) begin
          ph = PH_TRIG_LOW;
          ph_cnt = '0;
          echo_width = '0;
        end
      end
    endcase
    return r;
  endfunction

  // Offer one tick; on its transfer, queue either the typed or the predicted reading
  task automatic send_tick(input logic echo, input logic start, input bit typed,
                           input res_t want);
    bit   taken;
    res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    echo_level_i <= echo;
    start_request_i <= start;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      if (taken) begin
        predicted = ranger_tick(echo, start);
        pending_readings.push_back(typed ? want : predicted);
      end
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    case (idx)
      CFG_SPEED:   spd = data[SPEED_W-1:0];
      CFG_TIMEOUT: tmo = data[CNT_W-1:0];
      default:     maxd = data[MAXD_W-1:0];
    endcase
  endtask

  // Wait until every reading is back, let the pipe settle, then reprogram
  task automatic apply_settings(input logic [SPEED_W-1:0] speed,
                                input logic [CNT_W-1:0] timeout,
                                input logic [MAXD_W-1:0] max_dist);
    logic [CFG_DATA_W-1:0] sp_data;
    logic [CFG_DATA_W-1:0] to_data;
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    // junk above the register width must be dropped by the block
    sp_data = CFG_DATA_W'($urandom);
    sp_data[SPEED_W-1:0] = speed;
    to_data = CFG_DATA_W'($urandom);
    to_data[CNT_W-1:0] = timeout;
    write_reg(CFG_SPEED, sp_data);
    write_reg(CFG_TIMEOUT, to_data);
    write_reg(CFG_MAXDIST, max_dist);
    cfg_we_i <= 1'b0;
  endtask

  // Drive ranging traffic, mostly complete measurements, until enough
  // ticks have gone in and the sequencer is back at idle
  task automatic run_ranging(input int target);
    int   counted;
    int   pick;
    int   rise_pct;
    int   stay_pct;
    logic echo;
    logic start;
    counted = 0;
    rise_pct = 10;
    stay_pct = 90;
    while (counted < target || ph != PH_IDLE) begin
      case (ph)
        PH_IDLE: begin
          pick = $urandom_range(99);
          if (pick < 50 && counted < target) begin
            echo = 1'b0;
            start = 1'b1;
            case ($urandom_range(2))
              0: rise_pct = 2;
              1: rise_pct = 10;
              default: rise_pct = 50;
            endcase
            case ($urandom_range(2))
              0: stay_pct = 50;
              1: stay_pct = 90;
              default: stay_pct = 98;
            endcase
          end else if (pick < 60 && counted < target) begin
            echo = 1'b1;
            start = 1'b1;
          end else begin
            echo = $urandom_range(1);
            start = 1'b0;
          end
        end
        PH_TRIG_LOW, PH_TRIG_HIGH: begin
          // inputs are ignored while the trigger pulse runs
          echo = $urandom_range(1);
          start = $urandom_range(1);
        end
        PH_WAIT_RISE: begin
          echo = $urandom_range(99) < rise_pct;
          start = $urandom_range(99) < 5;
        end
        default: begin
          echo = $urandom_range(99) < stay_pct;
          start = $urandom_range(99) < 5;
        end
      endcase
      counted++;
      send_tick(echo, start, 1'b0, '0);
    end
  endtask

  // Receiver: random stall, or a long counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest queued reading
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $error("result transfer with no reading queued");
        mismatch_cnt++;
      end else begin
        oldest = pending_readings.pop_front();
        if (trigger_level_o !== oldest.trigger) begin
          $error("trigger_level: expected %0d, got %0d", oldest.trigger, trigger_level_o);
          mismatch_cnt++;
        end
        if (done_res_o !== oldest.done) begin
          $error("done_res: expected %0d, got %0d", oldest.done, done_res_o);
          mismatch_cnt++;
        end
        if (status_o !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, status_o);
          mismatch_cnt++;
        end
        if (distance_um_o !== oldest.distance) begin
          $error("distance_um: expected %0d, got %0d", oldest.distance, distance_um_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  typedef struct {
    logic              echo;
    logic              start;
    int                reps;
    bit                typed;
    logic              done;
    status_e           status;
    logic [DIST_W-1:0] dist_um;
  } plan_row_t;

  // Directed opening with reset settings: quiet idle, busy start, then one
  // full measurement with start and echo held high through the trigger pulse
  plan_row_t plan [9] = '{
    '{1'b0, 1'b0,   2, 1'b1, 1'b0, ST_MEASURED, 0},
    '{1'b1, 1'b0,   1, 1'b1, 1'b0, ST_MEASURED, 0},
    '{1'b1, 1'b1,   1, 1'b1, 1'b1, ST_BUSY,     2000000},
    '{1'b0, 1'b1,   1, 1'b1, 1'b0, ST_MEASURED, 0},
    '{1'b1, 1'b1, 140, 1'b0, 1'b0, ST_MEASURED, 0},
    '{1'b0, 1'b1,   3, 1'b0, 1'b0, ST_MEASURED, 0},
    '{1'b1, 1'b0,   5, 1'b0, 1'b0, ST_MEASURED, 0},
    '{1'b0, 1'b0,   1, 1'b1, 1'b1, ST_MEASURED, 857},
    '{1'b0, 1'b0,   2, 1'b0, 1'b0, ST_MEASURED, 0}
  };

  int unsigned set_speed [NUM_SETTINGS] = '{1023, 0, 1, 1000, 0, 0};
  int unsigned set_tmo   [NUM_SETTINGS] = '{37, 0, 1, 131071, 200, 0};
  int unsigned set_maxd  [NUM_SETTINGS] = '{8388607, 0, 5000000, 0, 0, 0};

  initial begin
    res_t want;
    set_speed[4] = $urandom_range(1000, 1);
    set_speed[5] = $urandom_range(1023, 0);
    set_tmo[5] = $urandom_range(60, 2);
    set_maxd[3] = $urandom_range(5000000, 0);
    set_maxd[4] = $urandom_range(5000000, 0);
    set_maxd[5] = $urandom_range(5000000, 0);
    send_idle_pct = 28;
    recv_idle_pct = 73;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[r]) begin
      repeat (plan[r].reps) begin
        want = '0;
        want.done = plan[r].done;
        want.status = plan[r].status;
        want.distance = plan[r].dist_um;
        send_tick(plan[r].echo, plan[r].start, plan[r].typed, want);
      end
    end

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      apply_settings(SPEED_W'(set_speed[s]), CNT_W'(set_tmo[s]), MAXD_W'(set_maxd[s]));
      // receiver-light first, then sender-light, then back to back
      case (s / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // fill the block against a long output hold-off once
      if (s == 0) hold_off_req = 1'b1;
      run_ranging(TICKS_PER_SETTING);
    end

    // drain and let the pipeline settle
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (pending_readings.size() != 0) begin
      $error("%0d readings never arrived", pending_readings.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/uer_pkg.sv
rtl/core/uer_cfg_regs.sv
rtl/core/uer_fsm.sv
rtl/core/ultrasonic_echo_ranger_top.sv
dv/ultrasonic_echo_ranger_top_tb.sv
